// File: rtl/can_rx_pkg.sv
// Shared constants, register indexes and the frame record of the CAN adapter frame receiver.
`default_nettype none
package can_rx_pkg;
	localparam int WINDOW_LIMIT_DEF = 16;
	localparam int MAX_PAYLOAD_DEF  = 8;
	localparam int FILTER_SLOTS_DEF = 4;

	localparam int SLOT_COUNT = 4;
	localparam int HDR_BYTES  = 7;
	localparam int MIN_SCAN   = 3;
	localparam int RESULT_CAP = 2;

	localparam logic [7:0] TYPE_DATA     = 8'h02;
	localparam logic [7:0] START_CODE_RST = 8'hAA;
	localparam logic [7:0] END_CODE_RST   = 8'h55;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 34;

	localparam logic [CFG_IW-1:0] REG_FILTER_ON = 3'd0;
	localparam logic [CFG_IW-1:0] REG_SLOT_A    = 3'd1;
	localparam logic [CFG_IW-1:0] REG_SLOT_B    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SLOT_C    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SLOT_D    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_START     = 3'd5;
	localparam logic [CFG_IW-1:0] REG_END       = 3'd6;

	localparam int SLOT_ALLOW_BIT = 32;
	localparam int SLOT_VALID_BIT = 33;

	typedef struct packed {
		logic [31:0] frame_id;
		logic [3:0]  payload_len;
		logic [63:0] payload;
		logic        run_last;
	} frame_t;
endpackage
`default_nettype wire

// File: rtl/can_rx_ifs.sv
// Channel interfaces: serial byte input, frame output and register write port.
`default_nettype none
interface can_rx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface can_rx_frame_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_id;
	logic [3:0]  payload_len;
	logic [63:0] payload;
	logic        run_last;
	modport source (output valid, output frame_id, output payload_len, output payload,
		output run_last, input ready);
	modport sink (input valid, input frame_id, input payload_len, input payload,
		input run_last, output ready);
endinterface

interface can_rx_cfg_if import can_rx_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/can_rx_scan.sv
// Front end: byte window, frame scan sequencer, identifier filter and config registers.
`default_nettype none
module can_rx_scan import can_rx_pkg::*; #(
	parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF,
	parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
	parameter int FILTER_SLOTS = FILTER_SLOTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	can_rx_byte_if.sink    rx,
	can_rx_cfg_if.sink     cfg,
	output frame_t         push_frame,
	output logic           push_valid,
	input  wire logic      push_ready
);
	localparam int DEPTH = WINDOW_LIMIT + 1;
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]          state_q;
	logic [7:0]          win_q [DEPTH];
	logic [FW-1:0]       fill_q;
	logic [1:0]          cnt_q;
	logic                pend_valid_q;
	frame_t              pend_q;

	logic                filter_on_q;
	logic [CFG_DW-1:0]   slot_q [SLOT_COUNT];
	logic [7:0]          start_q;
	logic [7:0]          end_q;

	logic                start_hit, end_hit, hdr_ok, too_short, denied, allowed;
	logic [IW-1:0]       s_idx, e_idx;
	logic [3:0]          len4;
	logic [31:0]         id;
	logic [63:0]         pay;
	logic [FW-1:0]       drop_n, shift_n;
	logic                do_drop, do_clear, go_done, do_emit, stall;
	logic [7:0]          win_sh [DEPTH];
	logic                accept;

	assign accept    = rx.valid && rx.ready;
	assign rx.ready  = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		start_hit = 1'b0;
		s_idx     = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (FW'(i) < fill_q && win_q[i] == start_q) begin
				start_hit = 1'b1;
				s_idx     = IW'(i);
			end
		end
	end

	assign len4      = win_q[2][3:0];
	assign hdr_ok    = (win_q[1] == TYPE_DATA) && (win_q[2] <= 8'(MAX_PAYLOAD));
	assign too_short = {1'b0, fill_q} < ((FW+1)'(HDR_BYTES + 1) + (FW+1)'(len4));
	assign id        = {win_q[3], win_q[4], win_q[5], win_q[6]};

	always_comb begin
		end_hit = 1'b0;
		e_idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if ((FW+1)'(i) >= ((FW+1)'(HDR_BYTES) + (FW+1)'(len4)) && FW'(i) < fill_q
				&& win_q[i] == end_q) begin
				end_hit = 1'b1;
				e_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		denied = 1'b0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (k < FILTER_SLOTS && slot_q[k][SLOT_VALID_BIT] && slot_q[k][31:0] == id)
				denied = !slot_q[k][SLOT_ALLOW_BIT];
		end
		if (!filter_on_q)
			denied = 1'b0;
	end
	assign allowed = !denied && (cnt_q < 2'(RESULT_CAP));

	always_comb begin
		pay = '0;
		for (int k = 0; k < 8; k++) begin
			if (4'(k) < len4)
				pay[8*k +: 8] = win_q[HDR_BYTES + k];
		end
	end

	// one scan step per cycle, unless a frame is held and the output queue is full
	always_comb begin
		do_drop  = 1'b0;
		do_clear = 1'b0;
		go_done  = 1'b0;
		do_emit  = 1'b0;
		stall    = 1'b0;
		drop_n   = FW'(1);
		if (fill_q < FW'(MIN_SCAN)) begin
			go_done = 1'b1;
		end else if (!start_hit) begin
			do_clear = 1'b1;
			go_done  = 1'b1;
		end else if (s_idx != '0) begin
			do_drop = 1'b1;
			drop_n  = FW'(s_idx);
		end else if (!hdr_ok) begin
			do_drop = 1'b1;
		end else if (too_short) begin
			go_done = 1'b1;
		end else if (!end_hit) begin
			do_drop = (fill_q > FW'(WINDOW_LIMIT));
			go_done = 1'b1;
		end else if (allowed && pend_valid_q && !push_ready) begin
			stall = 1'b1;
		end else begin
			do_emit = allowed;
			do_drop = 1'b1;
			drop_n  = FW'(e_idx) + FW'(1);
		end
	end

	assign shift_n = (state_q == S_IDLE) ? FW'(1) : drop_n;

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			win_sh[j] = win_q[j];
			for (int k = 1; k < DEPTH; k++) begin
				if (shift_n == FW'(k) && j + k < DEPTH)
					win_sh[j] = win_q[j + k];
			end
		end
	end

	always_comb begin
		push_valid = 1'b0;
		push_frame = pend_q;
		if (state_q == S_FLUSH) begin
			push_valid          = 1'b1;
			push_frame.run_last = 1'b1;
		end else if (state_q == S_SCAN && do_emit && pend_valid_q) begin
			push_valid          = 1'b1;
			push_frame.run_last = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (fill_q == FW'(DEPTH)) begin
				for (int j = 0; j < DEPTH - 1; j++)
					win_q[j] <= win_sh[j];
				win_q[DEPTH-1] <= rx.rx_byte;
			end else begin
				win_q[fill_q[IW-1:0]] <= rx.rx_byte;
			end
		end else if (state_q == S_SCAN && do_drop) begin
			for (int j = 0; j < DEPTH; j++)
				win_q[j] <= win_sh[j];
		end
		if (state_q == S_SCAN && do_emit) begin
			pend_q.frame_id    <= id;
			pend_q.payload_len <= len4;
			pend_q.payload     <= pay;
			pend_q.run_last    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (fill_q != FW'(DEPTH))
							fill_q <= fill_q + FW'(1);
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						if (do_clear)
							fill_q <= '0;
						else if (do_drop)
							fill_q <= (drop_n >= fill_q) ? '0 : fill_q - drop_n;
						if (do_emit) begin
							pend_valid_q <= 1'b1;
							cnt_q        <= cnt_q + 2'd1;
						end
						if (go_done)
							state_q <= pend_valid_q ? S_FLUSH : S_IDLE;
					end
				end
				S_FLUSH: begin
					if (push_ready) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_on_q <= 1'b0;
			for (int k = 0; k < SLOT_COUNT; k++)
				slot_q[k] <= '0;
			start_q <= START_CODE_RST;
			end_q   <= END_CODE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FILTER_ON: filter_on_q <= cfg.data[0];
				REG_SLOT_A:    slot_q[0]   <= cfg.data;
				REG_SLOT_B:    slot_q[1]   <= cfg.data;
				REG_SLOT_C:    slot_q[2]   <= cfg.data;
				REG_SLOT_D:    slot_q[3]   <= cfg.data;
				REG_START:     start_q     <= cfg.data[7:0];
				REG_END:       end_q       <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH)) else $error("window fill past depth");
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (state_q == S_SCAN || state_q == S_FLUSH))
		else $error("push outside scan");
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |-> pend_valid_q) else $error("flush with no held frame");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(RESULT_CAP)) else $error("frame count past cap");
endmodule
`default_nettype wire

// File: rtl/can_rx_queue.sv
// Back end: two-entry frame queue that drives the output channel.
`default_nettype none
module can_rx_queue import can_rx_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire frame_t    push_frame,
	input  wire logic      push_valid,
	output logic           push_ready,
	can_rx_frame_if.source frame
);
	frame_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop        = frame.valid && frame.ready;

	assign frame.valid       = (cnt_q != 2'd0);
	assign frame.frame_id    = mem_q[rd_q].frame_id;
	assign frame.payload_len = mem_q[rd_q].payload_len;
	assign frame.payload     = mem_q[rd_q].payload;
	assign frame.run_last    = mem_q[rd_q].run_last;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/can_adapter_frame_receiver.sv
// CAN adapter frame receiver: serial bytes in, filtered data frames out.
// Channels: rx carries one serial byte per transaction; frame carries one
//   decoded frame (identifier, length, payload, run_last); cfg writes one
//   register (0 filter_on, 1..4 filter slots a..d, 5 start code, 6 end code).
// Each accepted byte is appended to a 17-byte window and the window is
//   rescanned, one scan step per cycle unless the scan holds on a full
//   queue: skip to start code, drop a byte on a bad header, or extract
//   and drop a complete frame. Byte flow: rx is ready only while idle, so
//   a byte is accepted, then scanned (leftover bytes after a frame or a bad
//   header add steps), then flushed when it completed a frame, before the
//   next byte is taken. The scan sequencer in the front end sets this.
// Path: the scan step that extracts a frame holds it in a register; it
//   enters the output queue in the flush or when a second frame for the
//   same byte is extracted; further scan steps and a full queue delay it.
// Up to two frames per byte; run_last marks the last one for that byte.
// Frames pass a two-entry queue, so the scanner keeps going while the output
//   waits; when the queue is full and another frame is ready, the scan holds
//   and rx stays not ready.
// Reset empties the window and the queue, clears filtering, and sets the
//   start and end codes to 0xAA and 0x55. cfg is always ready.
`default_nettype none
module can_adapter_frame_receiver import can_rx_pkg::*; #(
	parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF,
	parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
	parameter int FILTER_SLOTS = FILTER_SLOTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	can_rx_byte_if.sink    rx,
	can_rx_frame_if.source frame,
	can_rx_cfg_if.sink     cfg
);
	frame_t push_frame;
	logic   push_valid;
	logic   push_ready;

	can_rx_scan #(
		.WINDOW_LIMIT(WINDOW_LIMIT),
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.FILTER_SLOTS(FILTER_SLOTS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.push_frame(push_frame),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	can_rx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_frame(push_frame),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.frame     (frame)
	);
endmodule
`default_nettype wire

// File: sim/can_adapter_frame_receiver_tb.sv
// Testbench for the CAN adapter frame receiver: random and directed byte streams, frame scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module can_adapter_frame_receiver_tb import can_rx_pkg::*;;

	// Predicts frames from accepted bytes and checks them in order.
	class frame_scoreboard;
		logic        flt_on;
		logic [33:0] slots [SLOT_COUNT];
		logic [7:0]  sc, ec;
		logic [7:0]  win [$];
		frame_t      pending [$];
		int          mismatches;
		int          frames_seen;

		function void clear();
			flt_on = 0;
			foreach (slots[k]) slots[k] = '0;
			sc = START_CODE_RST;
			ec = END_CODE_RST;
			win.delete();
			pending.delete();
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
			case (idx)
				REG_FILTER_ON: flt_on = d[0];
				REG_SLOT_A: slots[0] = d;
				REG_SLOT_B: slots[1] = d;
				REG_SLOT_C: slots[2] = d;
				REG_SLOT_D: slots[3] = d;
				REG_START: sc = d[7:0];
				REG_END: ec = d[7:0];
				default: ;
			endcase
		endfunction

		function bit denied(logic [31:0] id);
			if (!flt_on) return 0;
			for (int k = 0; k < FILTER_SLOTS_DEF; k++)
				if (slots[k][SLOT_VALID_BIT] && slots[k][31:0] == id)
					return !slots[k][SLOT_ALLOW_BIT];
			return 0;
		endfunction

		function void note_byte(logic [7:0] b);
			frame_t f;
			int     n, s, e, len;
			n = 0;
			if (win.size() >= WINDOW_LIMIT_DEF + 1) void'(win.pop_front());
			win.push_back(b);
			while (win.size() >= MIN_SCAN) begin
				s = win.size();
				foreach (win[i]) if (win[i] == sc) begin s = i; break; end
				if (s == win.size()) begin win.delete(); break; end
				repeat (s) void'(win.pop_front());
				if (win.size() < MIN_SCAN) break;
				if (win[1] == TYPE_DATA && win[2] <= MAX_PAYLOAD_DEF) begin
					len = win[2];
					if (win.size() < HDR_BYTES + len + 1) break;
					e = win.size();
					for (int i = HDR_BYTES + len; i < win.size(); i++)
						if (win[i] == ec) begin e = i; break; end
					if (e == win.size()) begin
						if (win.size() > WINDOW_LIMIT_DEF) void'(win.pop_front());
						break;
					end
					f.frame_id = {win[3], win[4], win[5], win[6]};
					if (!denied(f.frame_id) && n < RESULT_CAP) begin
						f.payload_len = 4'(len);
						f.payload = '0;
						for (int i = 0; i < len; i++) f.payload[8*i +: 8] = win[HDR_BYTES + i];
						f.run_last = 0;
						pending.push_back(f);
						n++;
					end
					repeat (e + 1) void'(win.pop_front());
				end else
					void'(win.pop_front());
			end
			if (n > 0) pending[pending.size() - 1].run_last = 1;
		endfunction

		function void check_frame(frame_t got);
			frame_t x;
			frames_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame %p", got);
				return;
			end
			x = pending.pop_front();
			if (x != got) begin
				mismatches++;
				if (mismatches <= 10) $display("frame mismatch: expected %p, got %p", x, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	can_rx_byte_if  rx_if ();
	can_rx_frame_if fr_if ();
	can_rx_cfg_if   cfg_if ();

	can_adapter_frame_receiver i_dut (
		.clk(clk), .arst_n(arst_n), .rx(rx_if.sink), .frame(fr_if.source), .cfg(cfg_if.sink)
	);

	frame_scoreboard board;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_sink;
	int  bytes_sent;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	// Receiver side: random stall, or a long hold when asked.
	initial begin
		fr_if.ready = 0;
		forever begin
			@(posedge clk);
			if (fr_if.valid && fr_if.ready)
				board.check_frame('{fr_if.frame_id, fr_if.payload_len, fr_if.payload,
					fr_if.run_last});
			fr_if.ready <= !hold_sink && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// valid stays up after the transaction; drain() or an idle gap in the next call takes it down
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 0;
			@(posedge clk);
		end
		rx_if.valid <= 1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task automatic drain();
		int t;
		t = 0;
		rx_if.valid <= 0;
		while (board.pending.size() != 0 && t < 200000) begin
			@(posedge clk);
			t++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
		cfg_if.valid <= 1;
		cfg_if.index <= idx;
		cfg_if.data <= d;
		do @(posedge clk); while (!cfg_if.ready);
		board.write_reg(idx, d);
		cfg_if.valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_frame(logic [31:0] id, int len, logic [7:0] end_b);
		send_byte(board.sc);
		send_byte(TYPE_DATA);
		send_byte(8'(len));
		for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8]);
		for (int i = 0; i < len; i++) send_byte(8'($urandom));
		send_byte(end_b);
	endtask

	logic [31:0] ids [4];

	// Mostly well-formed frames, some junk, broken headers and missing ends.
	task automatic random_traffic(int count);
		int r, len;
		logic [31:0] id;
		while (count > 0) begin
			r = $urandom_range(99);
			len = $urandom_range(MAX_PAYLOAD_DEF);
			id = ($urandom_range(1)) ? ids[$urandom_range(3)] : $urandom;
			if (r < 60) begin
				send_frame(id, len, board.ec);
				count -= len + 8;
			end else if (r < 70) begin
				send_byte(board.sc);
				send_byte($urandom_range(1) ? TYPE_DATA : 8'($urandom));
				send_byte($urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom));
				count -= 3;
			end else if (r < 78) begin
				send_frame(id, len, 8'($urandom));
				count -= len + 8;
			end else begin
				send_byte($urandom_range(3) == 0 ? board.ec : 8'($urandom));
				count--;
			end
		end
	endtask

	initial begin
		board = new();
		board.clear();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sink = 0;
		arst_n = 0;
		rx_if.valid = 0;
		rx_if.rx_byte = 0;
		cfg_if.valid = 0;
		cfg_if.index = REG_FILTER_ON;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (ids[k]) ids[k] = $urandom;

		// directed: extremes of id and length, junk bytes, a bad type and an overlong length
		send_frame(32'h0, 0, END_CODE_RST);
		send_frame(32'hFFFF_FFFF, MAX_PAYLOAD_DEF, END_CODE_RST);
		send_byte(8'h00); send_byte(8'hFF);
		send_byte(START_CODE_RST); send_byte(8'h03); send_byte(8'h01);
		send_byte(START_CODE_RST); send_byte(TYPE_DATA); send_byte(8'h09);
		drain();

		// filter with all slots: a deny, an allow, an invalid slot, and a deny in d that duplicates the id in b
		write_reg(REG_FILTER_ON, CFG_DW'(1));
		write_reg(REG_SLOT_A, {1'b1, 1'b0, ids[0]});
		write_reg(REG_SLOT_B, {1'b1, 1'b1, ids[1]});
		write_reg(REG_SLOT_C, {1'b0, 1'b0, ids[2]});
		write_reg(REG_SLOT_D, {1'b1, 1'b0, ids[1]});
		foreach (ids[k]) send_frame(ids[k], k * 2, END_CODE_RST);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			write_reg(REG_FILTER_ON, CFG_DW'(ph[0]));
			write_reg(REG_START,
				CFG_DW'(ph == 5 ? 8'hFF : (ph == 4 ? 8'h00 : 8'($urandom))));
			write_reg(REG_END,
				CFG_DW'(ph == 5 ? 8'h00 : (ph == 4 ? 8'hFF : 8'($urandom))));
			write_reg(CFG_IW'($urandom_range(REG_SLOT_A, REG_SLOT_D)),
				{$urandom_range(1) ? 2'b11 : 2'b10, ids[$urandom_range(3)]});
			if (ph == 2) begin
				hold_sink = 1;
				fork
					begin repeat (400) @(posedge clk); hold_sink = 0; end
				join_none
			end
			random_traffic(180);
			drain();
		end

		$display("%0d bytes sent, %0d frames checked across six idle/stall phases",
			bytes_sent, board.frames_seen);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
